// ===== rtl/stereo_downmix_decimator_fifo_macros.svh =====
// Assertion macros for the stereo downmix decimator.
// Used by the top level; depends on nothing else.
`ifndef STEREO_DOWNMIX_DECIMATOR_FIFO_MACROS_SVH
`define STEREO_DOWNMIX_DECIMATOR_FIFO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sddf_pkg.sv =====
// Shared types and constants for the stereo downmix decimator.
// No dependencies.
`timescale 1ns / 1ps

package sddf_pkg;

  localparam int DEFAULT_RING_DEPTH   = 1024;
  localparam int DEFAULT_BLOCK_LENGTH = 32;

  localparam int SAMPLE_W = 16;
  localparam int STEP_W   = 16;
  localparam int PHASE_W  = 17;
  localparam int SUM_W    = 19;
  localparam int MAG_W    = 18;
  localparam int COUNT_W  = 3;
  localparam int DROP_W   = 32;
  localparam int KIND_W   = 2;
  localparam int PROD_W   = 32;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [PHASE_W-1:0] PHASE_WRAP  = 17'h10000;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 16'd22050;
  localparam logic [13:0]        SIXTH_RECIP = 14'd10923;
  localparam logic [COUNT_W-1:0] WINDOW_MAX  = 3'd6;
  localparam logic [COUNT_W-1:0] WINDOW_QUAD = 3'd4;
  localparam logic [COUNT_W-1:0] FRAME_SAMPLES = 3'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_ACK,
    KIND_SAMPLE,
    KIND_NOT_READY
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_INCREMENT,
    REG_MUTE_ENABLE
  } cfg_reg_t;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

endpackage

// ===== rtl/sddf_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module sddf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/stereo_downmix_decimator_fifo.sv =====
// Top level of the stereo downmix decimator with its ring FIFO.
// Depends on sddf_pkg, sddf_ram and stereo_downmix_decimator_fifo_macros.svh.
`timescale 1ns / 1ps
`include "stereo_downmix_decimator_fifo_macros.svh"

// Each push transaction adds left plus right to a window of at most six
// samples and advances a phase accumulator by step_increment; when the phase
// reaches 65536 the window is averaged (divide by 4 for four samples, else
// by 6, truncating toward zero) and written to a RING_DEPTH-entry ring,
// overwriting the oldest entry and counting a drop when the ring is full.
// A wrapping push passes a multiply stage for the divide by 6, then the ring
// write. A pull transaction returns one not-ready result when fewer than
// BLOCK_LENGTH samples are queued; otherwise it streams BLOCK_LENGTH
// samples, the first after a ring read and then one per cycle while the
// output is ready, paced by the single registered read port of the ring
// RAM. Output backpressure stalls the stream without loss. Items are
// handled one at a time; the ring needs no clearing pass after reset.
module stereo_downmix_decimator_fifo
  import sddf_pkg::*;
#(
  parameter int RING_DEPTH   = DEFAULT_RING_DEPTH,
  parameter int BLOCK_LENGTH = DEFAULT_BLOCK_LENGTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [CFG_INDEX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic signed [SAMPLE_W-1:0]        left_sample,
  input  logic signed [SAMPLE_W-1:0]        right_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [KIND_W-1:0]                 kind,
  output logic signed [SAMPLE_W-1:0]        sample_out,
  output logic                              last,
  output logic                              backpressure,
  output logic [$clog2(RING_DEPTH+1)-1:0]   fill_level,
  output logic [DROP_W-1:0]                 drop_total
);

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int CNT_W  = $clog2(BLOCK_LENGTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_FIX,
    S_PULL
  } state_t;

  state_t state;

  logic [STEP_W-1:0]         step_increment;
  logic                      mute_enable;
  logic [PHASE_W-1:0]        phase;
  logic signed [SUM_W-1:0]   window_sum;
  logic [COUNT_W-1:0]        window_count;
  logic [PTR_W-1:0]          rd_ptr;
  logic [PTR_W-1:0]          wr_ptr;
  logic [FILL_W-1:0]         fill_count;
  logic [DROP_W-1:0]         drop_counter;

  // Averaging stage.
  logic signed [SUM_W-1:0]   avg_sum;
  logic                      avg_quad;
  logic                      avg_neg;
  logic [MAG_W-1:0]          avg_mag;
  logic [PROD_W-1:0]         avg_prod;

  // Block read stream.
  logic [CNT_W-1:0]          issued;
  logic [CNT_W-1:0]          emitted;
  logic                      data_ok;

  // Output register.
  kind_t                     out_kind;
  logic [SAMPLE_W-1:0]       out_sample;
  logic                      out_last;

  logic                      out_free;
  logic                      out_load;
  logic                      accept;
  logic signed [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0]        count_next;
  logic [PHASE_W-1:0]        phase_sum;
  logic                      wrap;
  logic [SUM_W-1:0]          sum_abs;
  logic [SAMPLE_W-1:0]       q_mul;
  logic [SUM_W-1:0]          q_times6;
  logic [SAMPLE_W-1:0]       q_div6;
  logic [SAMPLE_W-1:0]       q_mag;
  logic [SAMPLE_W-1:0]       avg_value;
  logic                      ring_full;
  logic [PTR_W-1:0]          rd_ptr_inc;
  logic [PTR_W-1:0]          wr_ptr_inc;
  logic                      ring_wr;
  logic                      ring_rd;
  logic [SAMPLE_W-1:0]       ring_rd_data;
  logic                      consume;
  logic                      block_done;

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Push arithmetic: window update and phase advance.
  always_comb begin
    if (window_count < WINDOW_MAX) begin
      sum_next   = window_sum + SUM_W'(left_sample) + SUM_W'(right_sample);
      count_next = window_count + FRAME_SAMPLES;
    end else begin
      sum_next   = window_sum;
      count_next = window_count;
    end
    phase_sum = phase + PHASE_W'(step_increment);
    wrap      = phase_sum >= PHASE_WRAP;
    sum_abs   = avg_sum[SUM_W-1] ? SUM_W'(-avg_sum) : SUM_W'(avg_sum);
  end

  // Divide by 6 through the reciprocal, corrected by one where it overshoots.
  always_comb begin
    q_mul    = avg_prod[PROD_W-1 -: SAMPLE_W];
    q_times6 = (SUM_W'(q_mul) << 2) + (SUM_W'(q_mul) << 1);
    q_div6   = (q_times6 > SUM_W'(avg_mag)) ? q_mul - 1'b1 : q_mul;
    q_mag    = avg_quad ? avg_mag[MAG_W-1:2] : q_div6;
    avg_value = avg_neg ? SAMPLE_W'(-q_mag) : q_mag;
  end

  assign ring_full  = fill_count >= FILL_W'(RING_DEPTH);
  assign rd_ptr_inc = (rd_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign wr_ptr_inc = (wr_ptr == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;

  // The ring is written only when the averaging step leaves S_FIX, and read
  // only in S_PULL, so a read never meets a write to the same entry.
  assign ring_wr    = (state == S_FIX) && out_free;
  assign consume    = (state == S_PULL) && data_ok && out_free;
  assign ring_rd    = (state == S_PULL) && (issued != CNT_W'(BLOCK_LENGTH))
                      && (!data_ok || consume);
  assign block_done = emitted == CNT_W'(BLOCK_LENGTH - 1);

  // A new result enters the output register in this cycle.
  assign out_load = (accept && ((op == OP_PUSH) ? !wrap
                                                : (fill_count < FILL_W'(BLOCK_LENGTH))))
                    || ring_wr || consume;

  sddf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr),
    .wr_addr (wr_ptr),
    .wr_data (avg_value),
    .rd_en   (ring_rd),
    .rd_addr (rd_ptr),
    .rd_data (ring_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      step_increment <= STEP_RESET;
      mute_enable    <= 1'b0;
      phase          <= '0;
      window_sum     <= '0;
      window_count   <= '0;
      rd_ptr         <= '0;
      wr_ptr         <= '0;
      fill_count     <= '0;
      drop_counter   <= '0;
      issued         <= '0;
      emitted        <= '0;
      data_ok        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_INCREMENT: step_increment <= cfg_data;
          REG_MUTE_ENABLE:    mute_enable    <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept && op == OP_PUSH) begin
            if (wrap) begin
              phase        <= phase_sum - PHASE_WRAP;
              avg_sum      <= sum_next;
              avg_quad     <= count_next == WINDOW_QUAD;
              window_sum   <= '0;
              window_count <= '0;
              state        <= S_MUL;
            end else begin
              phase        <= phase_sum;
              window_sum   <= sum_next;
              window_count <= count_next;
              out_kind     <= KIND_PUSH_ACK;
              out_sample   <= '0;
              out_last     <= 1'b1;
            end
          end else if (accept) begin
            if (fill_count < FILL_W'(BLOCK_LENGTH)) begin
              out_kind   <= KIND_NOT_READY;
              out_sample <= '0;
              out_last   <= 1'b1;
            end else begin
              // Results report the fill after the whole block, so take it now.
              fill_count <= fill_count - FILL_W'(BLOCK_LENGTH);
              issued     <= '0;
              emitted    <= '0;
              data_ok    <= 1'b0;
              state      <= S_PULL;
            end
          end
        end
        S_MUL: begin
          avg_neg  <= avg_sum[SUM_W-1];
          avg_mag  <= sum_abs[MAG_W-1:0];
          avg_prod <= PROD_W'(sum_abs[MAG_W-1:0]) * PROD_W'(SIXTH_RECIP);
          state    <= S_FIX;
        end
        S_FIX: begin
          if (out_free) begin
            wr_ptr <= wr_ptr_inc;
            if (ring_full) begin
              rd_ptr       <= rd_ptr_inc;
              drop_counter <= drop_counter + 1'b1;
            end else begin
              fill_count <= fill_count + 1'b1;
            end
            out_kind   <= KIND_PUSH_ACK;
            out_sample <= '0;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_PULL: begin
          if (consume) begin
            out_kind   <= KIND_SAMPLE;
            out_sample <= mute_enable ? '0 : ring_rd_data;
            out_last   <= block_done;
            emitted    <= emitted + 1'b1;
            if (block_done) begin
              state <= S_IDLE;
            end
          end
          if (ring_rd) begin
            rd_ptr  <= rd_ptr_inc;
            issued  <= issued + 1'b1;
            data_ok <= 1'b1;
          end else if (consume) begin
            data_ok <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign kind         = out_kind;
  assign sample_out   = out_sample;
  assign last         = out_last;
  assign fill_level   = fill_count;
  assign drop_total   = drop_counter;
  assign backpressure = ({1'b0, fill_count} + (FILL_W + 1)'(2 * BLOCK_LENGTH))
                        >= (FILL_W + 1)'(RING_DEPTH);

  `SDDF_ASSERT_NOW(a_fill_bound, clk, rst, 1'b1,
    fill_count <= FILL_W'(RING_DEPTH), "ring fill count exceeds the ring depth")
  `SDDF_ASSERT_NOW(a_read_ahead, clk, rst, state == S_PULL && data_ok,
    issued != emitted, "block stream holds data that was never read")
  `SDDF_ASSERT_NEXT(a_fix_result, clk, rst, state == S_FIX && out_free,
    out_valid && out_kind == KIND_PUSH_ACK && state == S_IDLE,
    "ring write did not produce its push acknowledgement")
  `SDDF_ASSERT_NEXT(a_pull_start, clk, rst,
    accept && op == OP_PULL && fill_count >= FILL_W'(BLOCK_LENGTH),
    state == S_PULL && !out_valid, "block pull did not start its read stream")

endmodule
